FILE: hw/rtl/acft_pkg.sv
// Package: widths, payload structs, row layout and codes for the frequency table.
package acft_pkg;

  localparam int unsigned CountWidth = 16;
  localparam int unsigned CmpWidth   = (CountWidth > 16) ? CountWidth : 16;
  localparam int unsigned NumGroups  = 16;
  localparam int unsigned NumLanes   = 16;

  typedef logic [CountWidth-1:0] cnt_t;
  typedef cnt_t [NumLanes-1:0]   lanes_t;

  localparam cnt_t Capacity = '1;

  typedef enum logic [1:0] {
    KIND_INC = 2'd0,
    KIND_DEC = 2'd1,
    KIND_SYM = 2'd2,
    KIND_VAL = 2'd3
  } kind_e;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_EXEC = 1'b1
  } state_e;

  typedef struct packed {
    kind_e       kind;
    logic [7:0]  symbol;
    logic [15:0] target;
  } req_t;

  typedef struct packed {
    logic [7:0]  found_symbol;
    logic [15:0] cum_start;
    logic [15:0] freq;
    logic        status;
  } res_t;

  // One group: exclusive lane prefixes and per-symbol counts
  typedef struct packed {
    lanes_t pref;
    lanes_t cnt;
  } row_t;

  typedef struct packed {
    logic       en;
    logic       up;
    logic [3:0] hi;
  } grp_upd_t;

  function automatic logic [CmpWidth-1:0] cmp_ext(input cnt_t x);
    return CmpWidth'(x);
  endfunction

  function automatic logic [15:0] out16(input cnt_t x);
    logic [CmpWidth-1:0] w;
    w = CmpWidth'(x);
    return w[15:0];
  endfunction

endpackage

FILE: hw/rtl/acft_row_store.sv
// Row memory: lane prefixes and counts per group, registered read, row valid bits.
module acft_row_store import acft_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       rd_en_i,
  input  logic [3:0] rd_addr_i,
  output row_t       rd_row_o,
  input  logic       wr_en_i,
  input  logic [3:0] wr_addr_i,
  input  row_t       wr_row_i
);

  row_t                 mem_q [NumGroups];
  row_t                 rd_data_q;
  logic [NumGroups-1:0] vld_q;
  logic                 rd_vld_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_row_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (wr_en_i) begin
        vld_q[wr_addr_i] <= 1'b1;
      end
      if (rd_en_i) begin
        rd_vld_q <= vld_q[rd_addr_i];
      end
    end
  end

  assign rd_row_o = rd_vld_q ? rd_data_q : '0;

endmodule

FILE: hw/rtl/acft_group_table.sv
// Group prefix registers, total count, group search over a target value.
module acft_group_table import acft_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic [15:0] target_i,
  output logic [3:0]  grp_o,
  input  logic [3:0]  rd_idx_i,
  output cnt_t        rd_pref_o,
  output logic        full_o,
  input  grp_upd_t    upd_i
);

  lanes_t gp_q, gp_d;
  cnt_t   total_q, total_d;

  always_comb begin
    grp_o = '0;
    for (int i = 0; i < NumGroups; i++) begin
      if (cmp_ext(gp_q[i]) <= CmpWidth'(target_i)) begin
        grp_o = 4'(i);
      end
    end
  end

  assign rd_pref_o = gp_q[rd_idx_i];
  assign full_o    = (total_q == Capacity);

  always_comb begin
    gp_d    = gp_q;
    total_d = total_q;
    if (upd_i.en) begin
      for (int i = 0; i < NumGroups; i++) begin
        if (4'(i) > upd_i.hi) begin
          gp_d[i] = upd_i.up ? gp_q[i] + cnt_t'(1) : gp_q[i] - cnt_t'(1);
        end
      end
      total_d = upd_i.up ? total_q + cnt_t'(1) : total_q - cnt_t'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gp_q    <= '0;
      total_q <= '0;
    end else begin
      gp_q    <= gp_d;
      total_q <= total_d;
    end
  end

endmodule

FILE: hw/rtl/acft_row_update.sv
// Lane search and read-modify of one group row.
module acft_row_update import acft_pkg::*; (
  input  req_t       req_i,
  input  row_t       row_i,
  input  cnt_t       gpref_i,
  input  logic       full_i,
  output logic [3:0] lane_o,
  output row_t       row_o,
  output logic       wr_o,
  output logic       refused_o
);

  logic [15:0] rem;
  logic [3:0]  found;
  logic [3:0]  lo;
  logic        up;
  logic        upd;
  cnt_t        cnt_old;

  always_comb begin
    rem   = req_i.target - out16(gpref_i);
    found = '0;
    for (int i = 0; i < NumLanes; i++) begin
      if (cmp_ext(row_i.pref[i]) <= CmpWidth'(rem)) begin
        found = 4'(i);
      end
    end
  end

  always_comb begin
    lo        = (req_i.kind == KIND_VAL) ? found : req_i.symbol[3:0];
    cnt_old   = row_i.cnt[lo];
    up        = (req_i.kind == KIND_INC);
    refused_o = 1'b0;
    upd       = 1'b0;
    case (req_i.kind)
      KIND_INC: begin
        refused_o = full_i;
        upd       = !full_i;
      end
      KIND_DEC: begin
        refused_o = (cnt_old == '0);
        upd       = (cnt_old != '0);
      end
      default: begin
        refused_o = 1'b0;
        upd       = 1'b0;
      end
    endcase
    row_o = row_i;
    if (upd) begin
      for (int i = 0; i < NumLanes; i++) begin
        if (4'(i) > lo) begin
          row_o.pref[i] = up ? row_i.pref[i] + cnt_t'(1) : row_i.pref[i] - cnt_t'(1);
        end
      end
      row_o.cnt[lo] = up ? cnt_old + cnt_t'(1) : cnt_old - cnt_t'(1);
    end
    lane_o = lo;
    wr_o   = upd;
  end

endmodule

FILE: hw/rtl/adaptive_cumulative_frequency_table_top.sv
// Top level: adaptive 256-symbol cumulative frequency table.
//
//   channel   | signals                  | transfer
//   ----------+--------------------------+-----------------------------
//   request   | start, busy, req_i       | edge with start & !busy
//   result    | done_o, res_o            | edge ending the done_o cycle
//
// For each request, the accept cycle reads the group row, the
// next cycle searches/modifies it and writes it back; busy is high then.
// The result is on res_o with done_o for one cycle after that; a new
// request is accepted in that same cycle. Reset clears all counts at once
// through per-row valid bits. The receiver cannot stall.
module adaptive_cumulative_frequency_table_top import acft_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start,
  output logic busy,
  input  req_t req_i,
  output logic done_o,
  output res_t res_o
);

  state_e     state_q, state_d;
  req_t       req_q;
  logic [3:0] hi_q;
  res_t       res_q, res_d;
  logic       done_q;

  logic       acc;
  logic [3:0] grp;
  logic [3:0] rd_addr;
  row_t       rd_row, new_row;
  cnt_t       gpref;
  logic       full;
  logic [3:0] lane;
  logic       wr;
  logic       refused;
  grp_upd_t   upd;
  logic       exec;

  assign busy    = (state_q == ST_EXEC);
  assign acc     = start && !busy;
  assign rd_addr = (req_i.kind == KIND_VAL) ? grp : req_i.symbol[7:4];

  acft_group_table u_grp (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .target_i  (req_i.target),
    .grp_o     (grp),
    .rd_idx_i  (hi_q),
    .rd_pref_o (gpref),
    .full_o    (full),
    .upd_i     (upd)
  );

  acft_row_store u_rows (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (acc),
    .rd_addr_i (rd_addr),
    .rd_row_o  (rd_row),
    .wr_en_i   (exec && wr),
    .wr_addr_i (hi_q),
    .wr_row_i  (new_row)
  );

  acft_row_update u_upd (
    .req_i     (req_q),
    .row_i     (rd_row),
    .gpref_i   (gpref),
    .full_i    (full),
    .lane_o    (lane),
    .row_o     (new_row),
    .wr_o      (wr),
    .refused_o (refused)
  );

  always_comb begin
    state_d = state_q;
    exec    = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (start) begin
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        exec    = 1'b1;
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    upd.en = exec && wr;
    upd.up = (req_q.kind == KIND_INC);
    upd.hi = hi_q;
    res_d.found_symbol = {hi_q, lane};
    res_d.cum_start    = out16(gpref + new_row.pref[lane]);
    res_d.freq         = out16(new_row.cnt[lane]);
    res_d.status       = refused;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= exec;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      req_q <= req_i;
      hi_q  <= rd_addr;
    end
    if (exec) begin
      res_q <= res_d;
    end
  end

  assign done_o = done_q;
  assign res_o  = res_q;

endmodule

FILE: tb/acft_predict_compare.sv
// Checker: predicts frequency-table results from accepted requests and compares each result.
module acft_predict_compare import acft_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic        busy_i,
  input  req_t        req_i,
  input  logic        done_i,
  input  res_t        res_i,
  output int unsigned fail_count_o,
  output int unsigned pending_o
);

  cnt_t sym_count  [256];
  cnt_t group_base [16];
  cnt_t lane_base  [256];
  cnt_t table_total;
  res_t expected_q [$];
  res_t want_res;

  function automatic void bump_symbol(input logic [7:0] s, input logic up);
    int hi;
    int lo;
    int i;
    hi = int'(s[7:4]);
    lo = int'(s[3:0]);
    for (i = hi + 1; i < 16; i++) begin
      group_base[i] = up ? group_base[i] + 1'b1 : group_base[i] - 1'b1;
    end
    for (i = lo + 1; i < 16; i++) begin
      lane_base[hi * 16 + i] = up ? lane_base[hi * 16 + i] + 1'b1 : lane_base[hi * 16 + i] - 1'b1;
    end
    sym_count[s] = up ? sym_count[s] + 1'b1 : sym_count[s] - 1'b1;
    table_total  = up ? table_total + 1'b1 : table_total - 1'b1;
  endfunction

  function automatic res_t table_step(input req_t r);
    res_t        o;
    logic [7:0]  s;
    logic [3:0]  grp;
    logic [3:0]  lane;
    logic [15:0] rem;
    int          i;
    s = r.symbol;
    o.status = 1'b0;
    case (r.kind)
      KIND_INC: begin
        if (table_total == Capacity) o.status = 1'b1;
        else bump_symbol(s, 1'b1);
      end
      KIND_DEC: begin
        if (sym_count[s] == '0) o.status = 1'b1;
        else bump_symbol(s, 1'b0);
      end
      KIND_VAL: begin
        grp = '0;
        for (i = 0; i < 16; i++) begin
          if (group_base[i] <= r.target) grp = 4'(i);
        end
        rem = r.target - group_base[grp];
        lane = '0;
        for (i = 0; i < 16; i++) begin
          if (lane_base[{grp, 4'(i)}] <= rem) lane = 4'(i);
        end
        s = {grp, lane};
      end
      default: ;
    endcase
    o.found_symbol = s;
    o.cum_start    = group_base[s[7:4]] + lane_base[s];
    o.freq         = sym_count[s];
    return o;
  endfunction

  task automatic check_field(input string name, input logic [15:0] want, input logic [15:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
      fail_count_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 256; i++) begin
        sym_count[i] = '0;
        lane_base[i] = '0;
      end
      for (int i = 0; i < 16; i++) group_base[i] = '0;
      table_total = '0;
      expected_q.delete();
      fail_count_o = 0;
      pending_o = 0;
    end else begin
      if (done_i) begin
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected result, expected none actual %h", $time, res_i);
          fail_count_o++;
        end else begin
          want_res = expected_q.pop_front();
          check_field("found_symbol", 16'(want_res.found_symbol), 16'(res_i.found_symbol));
          check_field("cum_start", want_res.cum_start, res_i.cum_start);
          check_field("freq", want_res.freq, res_i.freq);
          check_field("status", 16'(want_res.status), 16'(res_i.status));
        end
      end
      if (start_i && !busy_i) expected_q.push_back(table_step(req_i));
      pending_o = expected_q.size();
    end
  end

endmodule

FILE: tb/adaptive_cumulative_frequency_table_top_tb.sv
// Testbench top: request stimulus for the frequency table, timeout and verdict.
module adaptive_cumulative_frequency_table_top_tb;
  import acft_pkg::*;

  logic        clk_i  = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start  = 1'b0;
  req_t        req_i  = '0;
  logic        busy;
  logic        done_o;
  res_t        res_o;
  int unsigned fail_count;
  int unsigned pending;

  logic [7:0]  hot_syms [8];
  int unsigned burst_left = 0;
  logic        burst_on   = 1'b0;

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  adaptive_cumulative_frequency_table_top dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .req_i  (req_i),
    .done_o (done_o),
    .res_o  (res_o)
  );

  acft_predict_compare u_compare (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start),
    .busy_i       (busy),
    .req_i        (req_i),
    .done_i       (done_o),
    .res_i        (res_o),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  initial begin
    #36_000_000;
    $display("status: fail");
    $finish;
  end

  function automatic req_t req_of(input kind_e k, input logic [7:0] s, input logic [15:0] t);
    req_t r;
    r.kind   = k;
    r.symbol = s;
    r.target = t;
    return r;
  endfunction

  function automatic req_t rand_req(input int unsigned tmax);
    req_t        r;
    int unsigned n;
    n = $urandom_range(0, 99);
    if (n < 35) r.kind = KIND_INC;
    else if (n < 60) r.kind = KIND_DEC;
    else if (n < 80) r.kind = KIND_SYM;
    else r.kind = KIND_VAL;
    r.symbol = $urandom_range(0, 1) ? hot_syms[$urandom_range(0, 7)] : 8'($urandom_range(0, 255));
    case ($urandom_range(0, 7))
      0: r.target = 16'h0000;
      1: r.target = 16'hFFFF;
      2, 3, 4: r.target = 16'($urandom_range(0, tmax));
      default: r.target = 16'($urandom_range(0, 65535));
    endcase
    return r;
  endfunction

  task automatic send(input req_t r, input int unsigned gap);
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start <= 1'b1;
    req_i <= r;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
  endtask

  // hold off until every outstanding transfer has returned
  task automatic drain();
    start <= 1'b0;
    @(negedge clk_i);
    while (pending != 0) @(negedge clk_i);
    @(posedge clk_i);
  endtask

  task automatic random_phase(input int unsigned n, input int unsigned tmax);
    for (int unsigned k = 0; k < n; k++) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(10, 40);
        burst_on   = ($urandom_range(0, 2) == 0);
      end
      burst_left--;
      if ($urandom_range(0, 59) == 0) drain();
      send(rand_req(tmax), burst_on ? 0 : $urandom_range(0, 5));
    end
  endtask

  initial begin
    hot_syms[0] = 8'h00;
    hot_syms[1] = 8'hFF;
    for (int i = 2; i < 8; i++) hot_syms[i] = 8'($urandom_range(0, 255));

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty table, underflow, then a few counts across the symbol range, value lookups and decrements
    send(req_of(KIND_VAL, 8'h00, 16'h0000), $urandom_range(0, 5));
    send(req_of(KIND_VAL, 8'hFF, 16'hFFFF), $urandom_range(0, 5));
    send(req_of(KIND_DEC, 8'h00, 16'h0000), $urandom_range(0, 5));
    send(req_of(KIND_SYM, 8'hFF, 16'h0000), $urandom_range(0, 5));
    send(req_of(KIND_INC, 8'h00, 16'h0000), $urandom_range(0, 5));
    send(req_of(KIND_INC, 8'hFF, 16'h0000), $urandom_range(0, 5));
    send(req_of(KIND_INC, 8'hFF, 16'hFFFF), $urandom_range(0, 5));
    send(req_of(KIND_INC, 8'h5A, 16'h0000), $urandom_range(0, 5));
    send(req_of(KIND_INC, 8'hA5, 16'h0000), $urandom_range(0, 5));
    send(req_of(KIND_INC, 8'h0F, 16'h0000), $urandom_range(0, 5));
    send(req_of(KIND_INC, 8'hF0, 16'h0000), $urandom_range(0, 5));
    send(req_of(KIND_SYM, 8'hFF, 16'h0000), $urandom_range(0, 5));
    send(req_of(KIND_SYM, 8'h5A, 16'h0000), $urandom_range(0, 5));
    send(req_of(KIND_VAL, 8'h00, 16'h0000), $urandom_range(0, 5));
    send(req_of(KIND_VAL, 8'h00, 16'h0001), $urandom_range(0, 5));
    send(req_of(KIND_VAL, 8'h00, 16'h0002), $urandom_range(0, 5));
    send(req_of(KIND_VAL, 8'h00, 16'h0003), $urandom_range(0, 5));
    send(req_of(KIND_VAL, 8'h00, 16'h0007), $urandom_range(0, 5));
    send(req_of(KIND_VAL, 8'h00, 16'hFFFF), $urandom_range(0, 5));
    send(req_of(KIND_DEC, 8'hFF, 16'h0000), $urandom_range(0, 5));
    send(req_of(KIND_DEC, 8'h00, 16'h0000), $urandom_range(0, 5));
    send(req_of(KIND_DEC, 8'h00, 16'h0000), $urandom_range(0, 5));

    random_phase(235, 400);
    drain();

    send(req_of(KIND_INC, 8'h10, 16'h0000), $urandom_range(0, 5));
    send(req_of(KIND_VAL, 8'h00, 16'hFFFF), $urandom_range(0, 5));
    send(req_of(KIND_VAL, 8'h00, 16'hFFFE), $urandom_range(0, 5));
    send(req_of(KIND_SYM, 8'hFF, 16'h0000), $urandom_range(0, 5));
    send(req_of(KIND_DEC, 8'hFF, 16'h0000), $urandom_range(0, 5));
    send(req_of(KIND_INC, 8'h10, 16'h0000), $urandom_range(0, 5));
    send(req_of(KIND_INC, 8'h20, 16'h0000), $urandom_range(0, 5));
    send(req_of(KIND_VAL, 8'h00, 16'h0000), $urandom_range(0, 5));

    random_phase(235, 65535);

    drain();
    repeat (8) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
